>>> sv/stepper_floor_move_sequencer_unit_assert.svh
// Assertion helpers for the checker file sfm_check.sv.
`ifndef STEPPER_FLOOR_MOVE_SEQUENCER_UNIT_ASSERT_SVH
`define STEPPER_FLOOR_MOVE_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define SFM_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("sfm: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define SFM_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("sfm: next-cycle check failed");

`endif

>>> sv/sfm_pkg.sv
package sfm_pkg;

    localparam int unsigned TimerW = 16;
    localparam int unsigned GroupW = 16;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    localparam logic MOVE_HOME  = 1'b0;
    localparam logic MOVE_FLOOR = 1'b1;

    localparam logic [1:0] REG_PHASE_TICKS = 2'd0;
    localparam logic [1:0] REG_GROUP_LIMIT = 2'd1;
    localparam logic [1:0] REG_STOP_ENABLE = 2'd2;

    localparam logic [1:0] FLOOR_UNKNOWN = 2'd0;
    localparam logic [1:0] FLOOR_ONE     = 2'd1;
    localparam logic [1:0] FLOOR_TWO     = 2'd2;
    localparam logic [1:0] FLOOR_THREE   = 2'd3;

    localparam logic [2:0] PHASE_FIRST = 3'd0;
    localparam logic [2:0] PHASE_LAST  = 3'd7;

    localparam logic [TimerW-1:0] PHASE_TICKS_RST = 16'd1000;
    localparam logic [GroupW-1:0] GROUP_LIMIT_RST = 16'd512;

    typedef struct packed {
        logic [TimerW-1:0] phase_ticks;
        logic [GroupW-1:0] group_limit;
        logic              stop_enable;
    } t_cfg;

    typedef struct packed {
        logic       req_type;
        logic       move_kind;
        logic       home_up;
        logic [1:0] target_floor;
        logic       sensor_one_n;
        logic       sensor_two_n;
        logic       sensor_three_n;
    } t_req;

    typedef struct packed {
        logic              busy;
        logic              going_up;
        logic              homing;
        logic [2:0]        phase_index;
        logic [TimerW-1:0] phase_timer;
        logic [GroupW-1:0] group_count;
        logic [1:0]        dest_floor;
        logic [1:0]        recorded_floor;
        logic [2:0]        lamp;
        logic [3:0]        coil;
    } t_state;

    // Half-step coil patterns, phase 1 at index 0.
    function automatic logic [3:0] f_coil(input logic [2:0] idx);
        logic [3:0] pat;
        case (idx)
            3'd0:    pat = 4'b0001;
            3'd1:    pat = 4'b0011;
            3'd2:    pat = 4'b0010;
            3'd3:    pat = 4'b0110;
            3'd4:    pat = 4'b0100;
            3'd5:    pat = 4'b1100;
            3'd6:    pat = 4'b1000;
            default: pat = 4'b1001;
        endcase
        return pat;
    endfunction

    function automatic logic [2:0] f_lamp(input logic [1:0] floor);
        logic [2:0] lamp;
        unique case (floor)
            FLOOR_ONE:   lamp = 3'b001;
            FLOOR_TWO:   lamp = 3'b010;
            FLOOR_THREE: lamp = 3'b100;
            default:     lamp = 3'b000;
        endcase
        return lamp;
    endfunction

endpackage

>>> sv/sfm_ifs.sv
interface sfm_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic       move_kind;
    logic       home_up;
    logic [1:0] target_floor;
    logic       sensor_one_n;
    logic       sensor_two_n;
    logic       sensor_three_n;

    modport source (output valid, req_type, move_kind, home_up, target_floor,
                    sensor_one_n, sensor_two_n, sensor_three_n, input ready);
    modport sink   (input valid, req_type, move_kind, home_up, target_floor,
                    sensor_one_n, sensor_two_n, sensor_three_n, output ready);
endinterface

interface sfm_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] coil_drive;
    logic [2:0] floor_lamp;
    logic       moving;
    logic [1:0] floor_now;
    logic       move_done;

    modport source (output valid, coil_drive, floor_lamp, moving, floor_now, move_done,
                    input ready);
    modport sink   (input valid, coil_drive, floor_lamp, moving, floor_now, move_done,
                    output ready);
endinterface

interface sfm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/stepper_floor_move_sequencer_unit.sv
// Channel   Modport  Payload                                         Accepted when
// i_in      sink     req_type move_kind home_up target_floor sensors  valid & ready
// o_out     source   coil_drive floor_lamp moving floor_now move_done valid & ready
// i_cfg     sink     index (0 ticks, 1 groups, 2 stop) data           valid & ready
//
// One word in, one word out; each word passes through a single result register.
// i_in.ready is high whenever the result register is empty or being drained, so
// words flow back to back at one per clock.
// A stalled o_out holds the word and the move state; i_cfg is always ready.
// i_rst_n is synchronous, active low; it clears the move state and restores the
// register defaults.
module stepper_floor_move_sequencer_unit (
    input logic       i_clk,
    input logic       i_rst_n,
    sfm_in_if.sink    i_in,
    sfm_out_if.source o_out,
    sfm_cfg_if.sink   i_cfg
);
    import sfm_pkg::*;

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    t_req   req;
    logic   done;
    logic   accept;

    logic       r_out_valid;
    logic [3:0] r_coil_drive;
    logic [2:0] r_floor_lamp;
    logic       r_moving;
    logic [1:0] r_floor_now;
    logic       r_move_done;

    assign req = '{req_type:       i_in.req_type,
                   move_kind:      i_in.move_kind,
                   home_up:        i_in.home_up,
                   target_floor:   i_in.target_floor,
                   sensor_one_n:   i_in.sensor_one_n,
                   sensor_two_n:   i_in.sensor_two_n,
                   sensor_three_n: i_in.sensor_three_n};

    sfm_core u_core (
        .i_state (r_state),
        .i_req   (req),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_done  (done)
    );

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks <= PHASE_TICKS_RST;
            r_cfg.group_limit <= GROUP_LIMIT_RST;
            r_cfg.stop_enable <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_PHASE_TICKS: r_cfg.phase_ticks <= i_cfg.data;
                REG_GROUP_LIMIT: r_cfg.group_limit <= i_cfg.data;
                REG_STOP_ENABLE: r_cfg.stop_enable <= i_cfg.data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_coil_drive <= n_state.coil;
            r_floor_lamp <= n_state.lamp;
            r_moving     <= n_state.busy;
            r_floor_now  <= n_state.recorded_floor;
            r_move_done  <= done;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.coil_drive = r_coil_drive;
    assign o_out.floor_lamp = r_floor_lamp;
    assign o_out.moving     = r_moving;
    assign o_out.floor_now  = r_floor_now;
    assign o_out.move_done  = r_move_done;

endmodule

>>> sv/sfm_core.sv
module sfm_core (
    input  sfm_pkg::t_state i_state,
    input  sfm_pkg::t_req   i_req,
    input  sfm_pkg::t_cfg   i_cfg,
    output sfm_pkg::t_state o_state,
    output logic            o_done
);
    import sfm_pkg::*;

    typedef struct packed {
        logic   ended;
        t_state st;
    } t_gs;

    logic [2:0] sens_n;
    assign sens_n = {i_req.sensor_three_n, i_req.sensor_two_n, i_req.sensor_one_n};

    function automatic logic f_dest_low(input logic [1:0] dest, input logic [2:0] sn);
        logic low;
        unique case (dest)
            FLOOR_ONE:   low = !sn[0];
            FLOOR_TWO:   low = !sn[1];
            FLOOR_THREE: low = !sn[2];
            default:     low = 1'b0;
        endcase
        return low;
    endfunction

    function automatic logic [TimerW-1:0] f_reload(input t_cfg c);
        return (c.phase_ticks == '0) ? TimerW'(1) : c.phase_ticks;
    endfunction

    function automatic t_state f_finish(input t_state s_in, input logic [2:0] sn,
                                        input logic coils_off);
        t_state s;
        s = s_in;
        if (coils_off) begin
            s.coil = 4'b0000;
        end
        // Record the floor only on arrival.
        if (f_dest_low(s.dest_floor, sn)) begin
            s.recorded_floor = s.dest_floor;
            s.lamp           = f_lamp(s.dest_floor);
        end
        s.busy = 1'b0;
        return s;
    endfunction

    function automatic t_gs f_group_start(input t_state s_in, input logic [2:0] sn,
                                          input t_cfg c);
        t_state s;
        t_gs    r;
        s = s_in;
        if (!s.homing && s.recorded_floor != FLOOR_UNKNOWN
            && ((s.recorded_floor == FLOOR_ONE && s.dest_floor == FLOOR_THREE)
                || (s.recorded_floor == FLOOR_THREE && s.dest_floor == FLOOR_ONE))
            && !sn[1]) begin
            s.lamp = f_lamp(FLOOR_TWO);
        end
        if (c.stop_enable && f_dest_low(s.dest_floor, sn)) begin
            r.st    = f_finish(s, sn, 1'b1);
            r.ended = 1'b1;
        end else begin
            s.phase_index = s.going_up ? PHASE_LAST : PHASE_FIRST;
            s.coil        = f_coil(s.phase_index);
            s.phase_timer = f_reload(c);
            r.st          = s;
            r.ended       = 1'b0;
        end
        return r;
    endfunction

    always_comb begin
        t_state s;
        t_gs    gs;
        logic   done;
        logic   go;
        s    = i_state;
        gs   = '0;
        done = 1'b0;
        go   = 1'b0;
        if (i_req.req_type == REQ_START) begin
            if (!s.busy) begin
                if (i_req.move_kind == MOVE_HOME) begin
                    s.homing     = 1'b1;
                    s.going_up   = i_req.home_up;
                    s.dest_floor = FLOOR_ONE;
                    go           = 1'b1;
                end else if (s.recorded_floor != FLOOR_UNKNOWN
                             && i_req.target_floor != FLOOR_UNKNOWN
                             && i_req.target_floor != s.recorded_floor) begin
                    s.homing     = 1'b0;
                    s.going_up   = i_req.target_floor > s.recorded_floor;
                    s.dest_floor = i_req.target_floor;
                    go           = 1'b1;
                end
                if (go) begin
                    s.busy        = 1'b1;
                    s.group_count = '0;
                    if (i_cfg.group_limit == '0) begin
                        s    = f_finish(s, sens_n, 1'b0);
                        done = 1'b1;
                    end else begin
                        gs   = f_group_start(s, sens_n, i_cfg);
                        s    = gs.st;
                        done = gs.ended;
                    end
                end
            end
        end else if (s.busy) begin
            if (s.phase_timer > TimerW'(1)) begin
                s.phase_timer = s.phase_timer - TimerW'(1);
            end else begin
                s.phase_timer = '0;
                if (i_cfg.stop_enable && f_dest_low(s.dest_floor, sens_n)) begin
                    s    = f_finish(s, sens_n, 1'b1);
                    done = 1'b1;
                end else if ((s.going_up && s.phase_index == PHASE_FIRST)
                             || (!s.going_up && s.phase_index == PHASE_LAST)) begin
                    s.group_count = s.group_count + GroupW'(1);
                    if (s.group_count >= i_cfg.group_limit) begin
                        // Coils keep the last pattern.
                        s    = f_finish(s, sens_n, 1'b0);
                        done = 1'b1;
                    end else begin
                        gs   = f_group_start(s, sens_n, i_cfg);
                        s    = gs.st;
                        done = gs.ended;
                    end
                end else begin
                    s.phase_index = s.going_up ? s.phase_index - 3'd1 : s.phase_index + 3'd1;
                    s.coil        = f_coil(s.phase_index);
                    s.phase_timer = f_reload(i_cfg);
                end
            end
        end
        o_state = s;
        o_done  = done;
    end

endmodule

>>> sv/sfm_check.sv
`include "stepper_floor_move_sequencer_unit_assert.svh"

module sfm_check (
    input logic       i_clk,
    input logic       i_rst_n,
    sfm_in_if.sink    i_in,
    sfm_out_if.source o_out,
    sfm_cfg_if.sink   i_cfg
);

    logic [10:0] out_word;
    logic        out_stall;

    assign out_word  = {o_out.coil_drive, o_out.floor_lamp, o_out.moving, o_out.floor_now,
                        o_out.move_done};
    assign out_stall = o_out.valid && !o_out.ready;

    // Stalled word holds.
    `SFM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out.valid && $stable(out_word))

    // A word that ends a move never reports the move still running.
    `SFM_ASSERT_IMPLY(a_done_idle, i_clk, i_rst_n, o_out.valid && o_out.move_done, !o_out.moving)

    // Floor lamp is never more than one floor.
    `SFM_ASSERT_IMPLY(a_lamp_onehot, i_clk, i_rst_n, o_out.valid, $onehot0(o_out.floor_lamp))

    // An empty or draining result register must take a new word.
    `SFM_ASSERT_IMPLY(a_in_ready, i_clk, i_rst_n, !out_stall, i_in.ready && i_cfg.ready)

endmodule

bind stepper_floor_move_sequencer_unit sfm_check u_sfm_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out),
    .i_cfg   (i_cfg)
);

>>> tb/sfm_move_checker.sv
module sfm_move_checker
    import sfm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sfm_in_if    in_ch,
    sfm_out_if   out_ch,
    sfm_cfg_if   cfg_ch,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [3:0] coil_drive;
        logic [2:0] floor_lamp;
        logic       moving;
        logic [1:0] floor_now;
        logic       move_done;
    } t_result;

    // Half-step patterns, phase 1 in the low nibble.
    localparam logic [31:0] HALF_STEP = {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

    t_cfg        cfg;
    t_state      mv;
    t_result     result_q[$];
    int          fails = 0;
    int          pend = 0;
    int unsigned n_seen = 0;

    assign o_fail_count = fails;
    assign o_pending    = pend;

    task automatic report_mismatch(input string msg);
        fails++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic logic dest_sensor_low(input t_req rq);
        case (mv.dest_floor)
            FLOOR_ONE:   return !rq.sensor_one_n;
            FLOOR_TWO:   return !rq.sensor_two_n;
            FLOOR_THREE: return !rq.sensor_three_n;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic logic [TimerW-1:0] hold_ticks();
        return (cfg.phase_ticks == '0) ? 16'd1 : cfg.phase_ticks;
    endfunction

    function automatic void end_move(input t_req rq, input logic coils_off);
        if (coils_off) mv.coil = '0;
        if (dest_sensor_low(rq)) begin
            mv.recorded_floor = mv.dest_floor;
            mv.lamp = 3'b001 << (mv.dest_floor - 2'd1);
        end
        mv.busy = 1'b0;
    endfunction

    // Returns 1 when the move stops at the start of the group.
    function automatic logic begin_group(input t_req rq);
        if (!mv.homing && mv.recorded_floor != FLOOR_UNKNOWN &&
            ((mv.recorded_floor == FLOOR_ONE && mv.dest_floor == FLOOR_THREE) ||
             (mv.recorded_floor == FLOOR_THREE && mv.dest_floor == FLOOR_ONE)) &&
            !rq.sensor_two_n)
            mv.lamp = 3'b010;
        if (cfg.stop_enable && dest_sensor_low(rq)) begin
            end_move(rq, 1'b1);
            return 1'b1;
        end
        mv.phase_index = mv.going_up ? PHASE_LAST : PHASE_FIRST;
        mv.coil = HALF_STEP[mv.phase_index*4 +: 4];
        mv.phase_timer = hold_ticks();
        return 1'b0;
    endfunction

    function automatic t_result advance_move(input t_req rq);
        t_result r;
        logic    done;
        logic    go;
        done = 1'b0;
        go   = 1'b0;
        if (rq.req_type == REQ_START) begin
            if (!mv.busy) begin
                if (rq.move_kind == MOVE_HOME) begin
                    mv.homing     = 1'b1;
                    mv.going_up   = rq.home_up;
                    mv.dest_floor = FLOOR_ONE;
                    go = 1'b1;
                end else if (mv.recorded_floor != FLOOR_UNKNOWN &&
                             rq.target_floor != FLOOR_UNKNOWN &&
                             rq.target_floor != mv.recorded_floor) begin
                    mv.homing     = 1'b0;
                    mv.going_up   = rq.target_floor > mv.recorded_floor;
                    mv.dest_floor = rq.target_floor;
                    go = 1'b1;
                end
                if (go) begin
                    mv.busy        = 1'b1;
                    mv.group_count = '0;
                    if (cfg.group_limit == '0) begin
                        end_move(rq, 1'b0);
                        done = 1'b1;
                    end else begin
                        done = begin_group(rq);
                    end
                end
            end
        end else if (mv.busy) begin
            if (mv.phase_timer > 1) begin
                mv.phase_timer = mv.phase_timer - 1'b1;
            end else begin
                mv.phase_timer = '0;
                if (cfg.stop_enable && dest_sensor_low(rq)) begin
                    end_move(rq, 1'b1);
                    done = 1'b1;
                end else if ((mv.going_up && mv.phase_index == PHASE_FIRST) ||
                             (!mv.going_up && mv.phase_index == PHASE_LAST)) begin
                    mv.group_count = mv.group_count + 1'b1;
                    if (mv.group_count >= cfg.group_limit) begin
                        end_move(rq, 1'b0);
                        done = 1'b1;
                    end else begin
                        done = begin_group(rq);
                    end
                end else begin
                    mv.phase_index = mv.going_up ? mv.phase_index - 3'd1
                                                 : mv.phase_index + 3'd1;
                    mv.coil = HALF_STEP[mv.phase_index*4 +: 4];
                    mv.phase_timer = hold_ticks();
                end
            end
        end
        r.coil_drive = mv.coil;
        r.floor_lamp = mv.lamp;
        r.moving     = mv.busy;
        r.floor_now  = mv.recorded_floor;
        r.move_done  = done;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_req    rq;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg.phase_ticks = PHASE_TICKS_RST;
            cfg.group_limit = GROUP_LIMIT_RST;
            cfg.stop_enable = 1'b1;
            mv = '0;
            result_q.delete();
            pend <= 0;
        end else begin
            if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
                case (cfg_ch.index)
                    REG_PHASE_TICKS: cfg.phase_ticks = cfg_ch.data;
                    REG_GROUP_LIMIT: cfg.group_limit = cfg_ch.data;
                    REG_STOP_ENABLE: cfg.stop_enable = cfg_ch.data[0];
                    default: ;
                endcase
            end
            // Retire the older word before queuing the new one.
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got.coil_drive = out_ch.coil_drive;
                got.floor_lamp = out_ch.floor_lamp;
                got.moving     = out_ch.moving;
                got.floor_now  = out_ch.floor_now;
                got.move_done  = out_ch.move_done;
                if (result_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing pending",
                                              n_seen));
                end else begin
                    want = result_q.pop_front();
                    if (got.coil_drive !== want.coil_drive)
                        report_mismatch($sformatf("result %0d coil_drive %b, want %b",
                                                  n_seen, got.coil_drive, want.coil_drive));
                    if (got.floor_lamp !== want.floor_lamp)
                        report_mismatch($sformatf("result %0d floor_lamp %b, want %b",
                                                  n_seen, got.floor_lamp, want.floor_lamp));
                    if (got.moving !== want.moving)
                        report_mismatch($sformatf("result %0d moving %b, want %b",
                                                  n_seen, got.moving, want.moving));
                    if (got.floor_now !== want.floor_now)
                        report_mismatch($sformatf("result %0d floor_now %0d, want %0d",
                                                  n_seen, got.floor_now, want.floor_now));
                    if (got.move_done !== want.move_done)
                        report_mismatch($sformatf("result %0d move_done %b, want %b",
                                                  n_seen, got.move_done, want.move_done));
                end
                n_seen++;
            end
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
                rq.req_type       = in_ch.req_type;
                rq.move_kind      = in_ch.move_kind;
                rq.home_up        = in_ch.home_up;
                rq.target_floor   = in_ch.target_floor;
                rq.sensor_one_n   = in_ch.sensor_one_n;
                rq.sensor_two_n   = in_ch.sensor_two_n;
                rq.sensor_three_n = in_ch.sensor_three_n;
                result_q.push_back(advance_move(rq));
            end
            pend <= result_q.size();
        end
    end

endmodule

>>> tb/tb_stepper_floor_move_sequencer_unit.sv
module tb_stepper_floor_move_sequencer_unit;
    import sfm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned PHASE_WORDS = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int          fail_count;
    int          pending;
    int unsigned cycle_count = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int          hold_left = 0;

    sfm_in_if  in_ch ();
    sfm_out_if out_ch ();
    sfm_cfg_if cfg_ch ();

    stepper_floor_move_sequencer_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    sfm_move_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("stepper_floor_move_sequencer_unit test failed");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off when requested.
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic t_req mk_word(input logic req, input logic kind, input logic up,
                                     input logic [1:0] target, input logic s1,
                                     input logic s2, input logic s3);
        t_req w;
        w.req_type       = req;
        w.move_kind      = kind;
        w.home_up        = up;
        w.target_floor   = target;
        w.sensor_one_n   = s1;
        w.sensor_two_n   = s2;
        w.sensor_three_n = s3;
        return w;
    endfunction

    function automatic t_req random_word(input int unsigned low_pct);
        t_req w;
        w.req_type       = ($urandom_range(99) < 25) ? REQ_START : REQ_TICK;
        w.move_kind      = ($urandom_range(3) == 0) ? MOVE_HOME : MOVE_FLOOR;
        w.home_up        = 1'($urandom_range(1));
        w.target_floor   = 2'($urandom_range(3));
        w.sensor_one_n   = ($urandom_range(99) >= low_pct);
        w.sensor_two_n   = ($urandom_range(99) >= low_pct);
        w.sensor_three_n = ($urandom_range(99) >= low_pct);
        return w;
    endfunction

    // Keep valid up across back-to-back words; drop it only during a gap.
    task automatic offer_word(input t_req w);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.req_type       <= w.req_type;
        in_ch.move_kind      <= w.move_kind;
        in_ch.home_up        <= w.home_up;
        in_ch.target_floor   <= w.target_floor;
        in_ch.sensor_one_n   <= w.sensor_one_n;
        in_ch.sensor_two_n   <= w.sensor_two_n;
        in_ch.sensor_three_n <= w.sensor_three_n;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic set_regs(input logic [15:0] ticks, input logic [15:0] groups,
                            input logic stop);
        logic [1:0] idx;
        for (idx = REG_PHASE_TICKS; idx <= REG_STOP_ENABLE; idx++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx;
            case (idx)
                REG_PHASE_TICKS: cfg_ch.data <= ticks;
                REG_GROUP_LIMIT: cfg_ch.data <= groups;
                default:         cfg_ch.data <= {15'd0, stop};
            endcase
            do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        int unsigned ph;
        int unsigned k;
        int unsigned low_pct;
        logic [15:0] ticks;
        logic [15:0] groups;
        logic        stop;

        i_rst_n              <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.req_type       <= REQ_TICK;
        in_ch.move_kind      <= MOVE_HOME;
        in_ch.home_up        <= 1'b0;
        in_ch.target_floor   <= FLOOR_UNKNOWN;
        in_ch.sensor_one_n   <= 1'b1;
        in_ch.sensor_two_n   <= 1'b1;
        in_ch.sensor_three_n <= 1'b1;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= REG_PHASE_TICKS;
        cfg_ch.data          <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: idle tick, move with no known floor, homing that lands at once,
        // move to the floor already recorded.
        offer_word(mk_word(REQ_TICK, MOVE_FLOOR, 1'b1, FLOOR_TWO, 1'b0, 1'b0, 1'b0));
        offer_word(mk_word(REQ_START, MOVE_FLOOR, 1'b0, FLOOR_THREE, 1'b1, 1'b1, 1'b1));
        offer_word(mk_word(REQ_START, MOVE_HOME, 1'b1, FLOOR_TWO, 1'b0, 1'b1, 1'b1));
        offer_word(mk_word(REQ_START, MOVE_FLOOR, 1'b1, FLOOR_ONE, 1'b1, 1'b1, 1'b1));

        // Zero hold acts as one; no stop; a single group runs out on arrival.
        drain_results();
        set_regs(16'd0, 16'd1, 1'b0);
        offer_word(mk_word(REQ_START, MOVE_FLOOR, 1'b0, FLOOR_THREE, 1'b1, 1'b0, 1'b1));
        for (k = 1; k <= 8; k++) begin
            offer_word(mk_word(REQ_TICK, MOVE_HOME, 1'b0, FLOOR_UNKNOWN, 1'b1, 1'b1,
                               !(k == 2 || k == 8)));
            if (k == 3)
                offer_word(mk_word(REQ_START, MOVE_HOME, 1'b1, FLOOR_TWO, 1'b0, 1'b0, 1'b0));
        end

        // Zero group limit ends the move on the start word.
        drain_results();
        set_regs(16'd1, 16'd0, 1'b1);
        offer_word(mk_word(REQ_START, MOVE_FLOOR, 1'b1, FLOOR_TWO, 1'b1, 1'b0, 1'b1));
        offer_word(mk_word(REQ_START, MOVE_HOME, 1'b0, FLOOR_THREE, 1'b1, 1'b1, 1'b1));
        offer_word(mk_word(REQ_START, MOVE_FLOOR, 1'b0, FLOOR_UNKNOWN, 1'b0, 1'b1, 1'b0));

        // Long hold: one full phase of 150 ticks, then stop on the floor one sensor.
        drain_results();
        set_regs(16'd150, 16'd1, 1'b1);
        offer_word(mk_word(REQ_START, MOVE_HOME, 1'b0, FLOOR_ONE, 1'b1, 1'b1, 1'b1));
        repeat (149) begin
            offer_word(mk_word(REQ_TICK, MOVE_HOME, 1'b0, FLOOR_UNKNOWN,
                               1'($urandom_range(1)), 1'($urandom_range(1)),
                               1'($urandom_range(1))));
        end
        offer_word(mk_word(REQ_TICK, MOVE_HOME, 1'b0, FLOOR_UNKNOWN, 1'b0, 1'b1, 1'b1));

        for (ph = 0; ph < 8; ph++) begin
            drain_results();
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            if (ph == 0) begin
                ticks  = 16'd1;
                groups = 16'hFFFF;
                stop   = 1'b1;
            end else begin
                ticks  = ($urandom_range(9) == 0) ? 16'($urandom_range(5, 12))
                                                  : 16'($urandom_range(0, 3));
                groups = 16'($urandom_range(0, 4));
                stop   = 1'($urandom_range(1));
            end
            set_regs(ticks, groups, stop);
            low_pct = $urandom_range(5, 30);
            for (k = 0; k < PHASE_WORDS; k++) begin
                // Hold the result side long enough to back up the input.
                if (ph == 2 && k == 30) hold_left = 300;
                if (ph == 5 && k == 50) drain_results();
                offer_word(random_word(low_pct));
            end
        end

        drain_results();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("stepper_floor_move_sequencer_unit test passed");
        end else begin
            $display("stepper_floor_move_sequencer_unit test failed");
        end
        $finish;
    end

endmodule
